@@ sv/sdac_pkg.sv @@
// Shared constants and types for the soft depth alpha compositor.
`timescale 1ns / 1ps

package sdac_pkg;

	// Field widths
	localparam int DEPTH_W = 16;
	localparam int COLOR_W = 16;
	localparam int SUM_W   = DEPTH_W + 1;   // base + source, no wrap
	localparam int DIFF_W  = DEPTH_W + 2;   // sum - dest
	localparam int GAP_W   = 7;             // near band 0..127
	localparam int STEP_SHIFT  = 3;         // gap / 8
	localparam int ALPHA_W     = 4;
	localparam int ALPHA_LSB   = 12;
	localparam int PROD_W      = GAP_W + COLOR_W;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_DEPTH = 1'b0,
		REG_SCALE_MODE = 1'b1
	} cfg_reg_t;

	// Depth classification of one pixel
	typedef struct packed {
		logic              behind;
		logic              far;
		logic [GAP_W-1:0]  gap;
	} depth_cls_t;

endpackage

@@ sv/sdac_if.sv @@
// Valid/ready channel interfaces for pixel requests and composited results.
`timescale 1ns / 1ps

interface sdac_in_if import sdac_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] source_depth;
	logic [COLOR_W-1:0] source_color;
	logic [DEPTH_W-1:0] dest_depth;
	logic               span_last;

	modport source (output valid, source_depth, source_color, dest_depth, span_last,
		input ready);
	modport sink (input valid, source_depth, source_color, dest_depth, span_last,
		output ready);
endinterface

interface sdac_out_if import sdac_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] out_color;
	logic               span_end;

	modport source (output valid, out_color, span_end, input ready);
	modport sink (input valid, out_color, span_end, output ready);
endinterface

@@ sv/soft_depth_alpha_compositor.sv @@
// Soft depth alpha compositor: three-stage pixel pipeline with config registers.
`timescale 1ns / 1ps

// Usage
//   pix_in  : one request per pixel: source_depth, source_color (ARGB4444),
//             dest_depth and span_last. Accepted when valid and ready are high.
//   pix_out : one result per request: out_color and span_end, same order.
//   cfg_*   : write port; index 0 is base_depth, index 1 is scale_mode.
//             Write only while no request is in flight.
// Throughput: one pixel per clock. The three pipeline registers advance
//   together, so a request enters every cycle unless the output stalls.
// Path: a request accepted on pix_in passes through stage 1 depth sum,
//   stage 2 depth compare and stage 3 alpha multiply and select into the
//   output register, from which it is shown on pix_out.
// Stall: while pix_out.valid is high and pix_out.ready is low, every stage
//   holds and pix_in.ready drops; nothing is lost or repeated. An empty
//   output register always lets the pipeline advance.
// Reset: arst_n clears all stage valid bits and both config registers
//   (base_depth 0, stepped alpha mode). No clearing pass is needed.
module soft_depth_alpha_compositor import sdac_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sdac_in_if.sink               pix_in,
	sdac_out_if.source            pix_out
);

	// Configuration registers
	logic signed [DEPTH_W-1:0] base_depth_q;
	logic                      scale_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_depth_q <= '0;
			scale_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BASE_DEPTH: base_depth_q <= $signed(cfg_data[DEPTH_W-1:0]);
				REG_SCALE_MODE: scale_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Whole pipeline advances unless the output register holds a stalled result
	logic adv;
	assign adv          = !pix_out.valid || pix_out.ready;
	assign pix_in.ready = adv;

	// Stage 1: pixel depth sum
	logic                      valid_s1;
	logic signed [SUM_W-1:0]   sum_s1;
	logic [DEPTH_W-1:0]        dest_s1;
	logic [COLOR_W-1:0]        color_s1;
	logic                      last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pix_in.valid) begin
			sum_s1   <= $signed({base_depth_q[DEPTH_W-1], base_depth_q})
				+ $signed({pix_in.source_depth[DEPTH_W-1], pix_in.source_depth});
			dest_s1  <= pix_in.dest_depth;
			color_s1 <= pix_in.source_color;
			last_s1  <= pix_in.span_last;
		end
	end

	// Stage 2: compare against screen depth, classify behind / far / near
	logic signed [DIFF_W-1:0] diff;
	depth_cls_t               cls;

	always_comb begin
		diff = $signed({sum_s1[SUM_W-1], sum_s1})
			- $signed({{(DIFF_W-DEPTH_W){dest_s1[DEPTH_W-1]}}, dest_s1});
		cls.behind = diff[DIFF_W-1];
		cls.far    = !diff[DIFF_W-1] && (|diff[DIFF_W-2:GAP_W]);
		cls.gap    = diff[GAP_W-1:0];
	end

	logic               valid_s2;
	depth_cls_t         cls_s2;
	logic [COLOR_W-1:0] color_s2;
	logic               last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			cls_s2   <= cls;
			color_s2 <= color_s1;
			last_s2  <= last_s1;
		end
	end

	// Stage 3: alpha scale or step, then select the result
	logic [PROD_W-1:0]  prod;
	logic [COLOR_W-1:0] scaled;
	logic [COLOR_W-1:0] near_color;
	logic [COLOR_W-1:0] result;

	always_comb begin
		// gap * color stays below 2^23, so the shifted value fits 16 bits
		prod   = PROD_W'(cls_s2.gap) * PROD_W'(color_s2);
		scaled = prod[PROD_W-1:GAP_W];
		if (scale_mode_q) begin
			near_color = {scaled[COLOR_W-1:ALPHA_LSB], color_s2[ALPHA_LSB-1:0]};
		end else begin
			near_color = {color_s2[COLOR_W-1:ALPHA_LSB] | cls_s2.gap[GAP_W-1:STEP_SHIFT],
				color_s2[ALPHA_LSB-1:0]};
		end
		if (cls_s2.behind) begin
			result = '0;
		end else if (cls_s2.far) begin
			result = scale_mode_q ? color_s2
				: {{ALPHA_W{1'b1}}, color_s2[ALPHA_LSB-1:0]};
		end else begin
			result = near_color;
		end
	end

	logic               valid_s3;
	logic [COLOR_W-1:0] color_s3;
	logic               last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			color_s3 <= result;
			last_s3  <= last_s2;
		end
	end

	assign pix_out.valid     = valid_s3;
	assign pix_out.out_color = color_s3;
	assign pix_out.span_end  = last_s3;

endmodule

@@ sv/sdac_checker.sv @@
// Port-level checks for the soft depth alpha compositor, bound to the top level.
`timescale 1ns / 1ps

module sdac_checker import sdac_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COLOR_W-1:0] out_color,
	input logic               span_end
);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_color) && $stable(span_end))
		else $error("stalled result changed");

	// Input is refused only while the output register is stalled
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input refused without output stall");

	// With out_ready held high while a request passes the stages, its result is shown
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing after pipeline latency");

	// Nothing is shown right after reset
	a_reset_empty: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("result shown after reset");

endmodule

bind soft_depth_alpha_compositor sdac_checker u_sdac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_color (pix_out.out_color),
	.span_end  (pix_out.span_end)
);

@@ bench/soft_depth_alpha_compositor_test.sv @@
// Self-checking testbench for the soft depth alpha compositor pixel pipeline.
`timescale 1ns / 1ps

module soft_depth_alpha_compositor_test;
	import sdac_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int PIPE_LATENCY    = 3;
	localparam int DIRECTED_N      = 23;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int HOLD_AFTER      = 400;
	localparam int HOLD_CYCLES     = 300;
	localparam int NEAR_MAX        = 127;
	localparam int SCALE_SHIFT     = 7;
	localparam int STEP_DIV        = 8;
	localparam logic [COLOR_W-1:0] ALPHA_MASK = 16'hF000;
	localparam logic [COLOR_W-1:0] RGB_MASK   = 16'h0FFF;

	typedef struct {
		logic signed [DEPTH_W-1:0] sdepth;
		logic [COLOR_W-1:0]        color;
		logic signed [DEPTH_W-1:0] ddepth;
		logic                      last;
	} pixel_t;

	typedef struct {
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_result_t;

	// One directed request with the settings it runs under
	typedef struct {
		logic signed [DEPTH_W-1:0] base;
		logic                      scale;
		logic signed [DEPTH_W-1:0] sdepth;
		logic [COLOR_W-1:0]        color;
		logic signed [DEPTH_W-1:0] ddepth;
		logic                      last;
		logic                      typed;
		logic [COLOR_W-1:0]        want_color;
	} directed_row_t;

	typedef enum int {RX_FLOW, RX_HALF, RX_SPARSE} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sdac_in_if  pix_in();
	sdac_out_if pix_out();

	soft_depth_alpha_compositor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_in   (pix_in),
		.pix_out  (pix_out)
	);

	// Settings as the block holds them
	logic signed [DEPTH_W-1:0] depth_offset = '0;
	logic                      scale_sel = 1'b0;

	pixel_result_t pending_results[$];
	directed_row_t directed_rows[DIRECTED_N];
	int mismatches = 0;
	int cycle_count = 0;
	int pixels_sent = 0;
	int burst_left = 0;
	bit long_hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Expected composited color for one pixel under the current settings
	function automatic logic [COLOR_W-1:0] blend_pixel(input pixel_t px);
		int sum;
		int gap;
		logic [31:0] scaled;
		sum = int'(depth_offset) + int'(px.sdepth);
		if (sum < int'(px.ddepth))
			return '0;
		if (sum > int'(px.ddepth) + NEAR_MAX)
			return scale_sel ? px.color : (px.color | ALPHA_MASK);
		gap = sum - int'(px.ddepth);
		if (scale_sel) begin
			scaled = (32'(gap) * 32'(px.color)) >> SCALE_SHIFT;
			return ((scaled > 32'hFFFF) ? ALPHA_MASK : (scaled[15:0] & ALPHA_MASK))
				| (px.color & RGB_MASK);
		end
		return px.color | COLOR_W'((gap / STEP_DIV) << ALPHA_LSB);
	endfunction

	// Random pixel, mostly placed in or around the near band
	task automatic make_pixel(output pixel_t px);
		int kind;
		int gap;
		int sd;
		int dd;
		px.sdepth = DEPTH_W'($urandom);
		px.color = COLOR_W'($urandom);
		px.ddepth = DEPTH_W'($urandom);
		px.last = 1'($urandom);
		kind = $urandom_range(0, 9);
		if (kind <= 7) begin
			if (kind <= 5)
				gap = $urandom_range(0, NEAR_MAX);
			else if (kind == 6) begin
				case ($urandom_range(0, 3))
					0: gap = -1;
					1: gap = 0;
					2: gap = NEAR_MAX;
					default: gap = NEAR_MAX + 1;
				endcase
			end else
				gap = int'($urandom_range(0, 800)) - 400;
			for (int tries = 0; tries < 8; tries++) begin
				dd = $signed(DEPTH_W'($urandom));
				sd = dd + gap - int'(depth_offset);
				if (sd >= -32768 && sd <= 32767) begin
					px.sdepth = DEPTH_W'(sd);
					px.ddepth = DEPTH_W'(dd);
					break;
				end
			end
		end
	endtask

	// Offer one request and wait for it to be taken; may idle between bursts
	task automatic offer_pixel(input pixel_t px, input logic [COLOR_W-1:0] want_color);
		pending_results.push_back('{want_color, px.last});
		pix_in.valid <= 1'b1;
		pix_in.source_depth <= px.sdepth;
		pix_in.source_color <= px.color;
		pix_in.dest_depth <= px.ddepth;
		pix_in.span_last <= px.last;
		@(posedge clk);
		while (!pix_in.ready)
			@(posedge clk);
		pixels_sent++;
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(0, 40);
			if ($urandom_range(0, 2) != 0) begin
				pix_in.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// Drain the pipeline, then write both registers
	task automatic apply_settings(input logic signed [DEPTH_W-1:0] base, input logic scale);
		pix_in.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_BASE_DEPTH;
		cfg_data <= base;
		@(posedge clk);
		// upper bits of the mode write are don't-care
		cfg_index <= REG_SCALE_MODE;
		cfg_data <= {15'($urandom), scale};
		@(posedge clk);
		cfg_we <= 1'b0;
		depth_offset = base;
		scale_sel = scale;
	endtask

	// Result checker
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: color %h span_end %b",
						pix_out.out_color, pix_out.span_end);
			end else begin
				want = pending_results.pop_front();
				if (pix_out.out_color !== want.color || pix_out.span_end !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: color exp %h got %h, span_end exp %b got %b",
							want.color, pix_out.out_color, want.last, pix_out.span_end);
				end
			end
		end
	end

	// Receiver: stall patterns in segments, plus one long hold-off
	initial begin
		rx_mode_t mode;
		int seg;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && pixels_sent >= HOLD_AFTER) begin
				pix_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold_done = 1'b1;
			end else begin
				mode = rx_mode_t'($urandom_range(0, 2));
				seg = $urandom_range(10, 150);
				repeat (seg) begin
					case (mode)
						RX_FLOW: pix_out.ready <= 1'b1;
						RX_HALF: pix_out.ready <= 1'($urandom);
						default: pix_out.ready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Stimulus
	initial begin
		directed_row_t row;
		pixel_t px;
		logic signed [DEPTH_W-1:0] base;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BASE_DEPTH;
		cfg_data = '0;
		pix_in.valid = 1'b0;
		pix_in.source_depth = '0;
		pix_in.source_color = '0;
		pix_in.dest_depth = '0;
		pix_in.span_last = 1'b0;

		// base, scale, source depth, color, dest depth, last, typed, expected color
		directed_rows = '{
			// reset settings: stepped alpha, zero base
			'{16'h0000, 1'b0, 16'h0000, 16'h1234, 16'h0000, 1'b0, 1'b1, 16'h1234},
			'{16'h0000, 1'b0, 16'hFFFF, 16'h1234, 16'h0000, 1'b0, 1'b1, 16'h0000},
			'{16'h0000, 1'b0, 16'h007F, 16'h1234, 16'h0000, 1'b0, 1'b1, 16'hF234},
			'{16'h0000, 1'b0, 16'h0080, 16'h1234, 16'h0000, 1'b1, 1'b1, 16'hF234},
			'{16'h0000, 1'b0, 16'h0008, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h1000},
			'{16'h0000, 1'b0, 16'h7FFF, 16'hFFFF, 16'h8000, 1'b1, 1'b1, 16'hFFFF},
			'{16'h0000, 1'b0, 16'h8000, 16'hFFFF, 16'h7FFF, 1'b0, 1'b1, 16'h0000},
			'{16'h0000, 1'b0, 16'h0045, 16'h0A5A, 16'h0000, 1'b0, 1'b0, 16'h0000},
			// scaled alpha
			'{16'h0000, 1'b1, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 16'h0FFF},
			'{16'h0000, 1'b1, 16'h007F, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'h0000},
			'{16'h0000, 1'b1, 16'h0080, 16'h5A5A, 16'h0000, 1'b1, 1'b1, 16'h5A5A},
			'{16'h0000, 1'b1, 16'h0040, 16'h8000, 16'h0000, 1'b0, 1'b1, 16'h4000},
			'{16'h0000, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 16'h0000},
			'{16'h0000, 1'b1, 16'h0033, 16'hC3C3, 16'h0010, 1'b0, 1'b0, 16'h0000},
			// largest base, including a depth sum beyond 16 bits
			'{16'h7FFF, 1'b1, 16'h7FFF, 16'hABCD, 16'h7FFF, 1'b0, 1'b1, 16'hABCD},
			'{16'h7FFF, 1'b1, 16'h8000, 16'hF0F0, 16'hFFFF, 1'b0, 1'b1, 16'h00F0},
			'{16'h7FFF, 1'b1, 16'h8000, 16'hFFFF, 16'hFF80, 1'b1, 1'b0, 16'h0000},
			// most negative base
			'{16'h8000, 1'b0, 16'h8000, 16'hFFFF, 16'h8000, 1'b0, 1'b1, 16'h0000},
			'{16'h8000, 1'b0, 16'h7FFF, 16'h0ABC, 16'hFFFF, 1'b0, 1'b1, 16'h0ABC},
			'{16'h8000, 1'b0, 16'h7FFF, 16'h0000, 16'hFF80, 1'b0, 1'b1, 16'hF000},
			'{16'h8000, 1'b0, 16'h7FFF, 16'h0123, 16'hFF7F, 1'b1, 1'b1, 16'hF123},
			'{16'h8000, 1'b0, 16'h0000, 16'h5555, 16'h7FFF, 1'b1, 1'b1, 16'h0000},
			'{16'h8000, 1'b1, 16'h7FFF, 16'h7777, 16'hFF81, 1'b0, 1'b0, 16'h0000}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, settings change only between drained groups
		for (int i = 0; i < DIRECTED_N; i++) begin
			row = directed_rows[i];
			if (row.base !== depth_offset || row.scale !== scale_sel)
				apply_settings(row.base, row.scale);
			px = '{row.sdepth, row.color, row.ddepth, row.last};
			offer_pixel(px, row.typed ? row.want_color : blend_pixel(px));
		end

		// random part, one setting per phase
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: base = 16'h0000;
				1: base = 16'h7FFF;
				2: base = 16'h8000;
				default: base = DEPTH_W'($urandom);
			endcase
			apply_settings(base, 1'(phase % 2));
			repeat (ITEMS_PER_PHASE) begin
				make_pixel(px);
				offer_pixel(px, blend_pixel(px));
			end
		end

		pix_in.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
